// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; included by sql_token_scanner.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset.
`define SCN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SCN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCN_ASSERT(lbl, prop, msg)
`define SCN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/sqlscan_pkg.sv =====
package sqlscan_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int QDEPTH = 8;
  localparam int QAW = $clog2(QDEPTH);
  localparam int MAX_RES = 3;

  localparam logic [3:0] K_INT     = 4'd0;
  localparam logic [3:0] K_FLOAT   = 4'd1;
  localparam logic [3:0] K_STRING  = 4'd2;
  localparam logic [3:0] K_IDENT   = 4'd3;
  localparam logic [3:0] K_OP      = 4'd4;
  localparam logic [3:0] K_COMMA   = 4'd5;
  localparam logic [3:0] K_SEMI    = 4'd6;
  localparam logic [3:0] K_LPAREN  = 4'd7;
  localparam logic [3:0] K_RPAREN  = 4'd8;
  localparam logic [3:0] K_DOT     = 4'd9;
  localparam logic [3:0] K_UNKNOWN = 4'd10;
  localparam logic [3:0] K_END     = 4'd11;
  localparam logic [3:0] K_ERROR   = 4'd12;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic        has;
    logic        first;
    logic        last;
    logic [15:0] line;
    logic [15:0] col;
  } item_t;

  typedef struct packed {
    logic [1:0]          n;
    item_t [MAX_RES-1:0] item;
  } push_t;

  typedef struct packed {
    logic [QAW:0] count;
  } qstat_t;

  function automatic logic is_digit(logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
               (c == 8'h5f);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic item_t mk_item(logic [3:0] kind, logic [7:0] ch, logic has,
                                    logic first, logic last, logic [15:0] line,
                                    logic [15:0] col);
    item_t r;
    r.kind  = kind;
    r.ch    = has ? ch : 8'd0;
    r.has   = has;
    r.first = first;
    r.last  = last;
    r.line  = line;
    r.col   = col;
    mk_item = r;
  endfunction

endpackage

// ===== rtl/core/sqlscan_front.sv =====
module sqlscan_front #(
  parameter int POSITION_WIDTH = sqlscan_pkg::POS_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             char_code,
  input  logic                   end_of_input,
  output sqlscan_pkg::push_t     push
);

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_INT       = 4'd1;
  localparam logic [3:0] M_INT_DOT   = 4'd2;
  localparam logic [3:0] M_FRAC      = 4'd3;
  localparam logic [3:0] M_FRAC_E    = 4'd4;
  localparam logic [3:0] M_EXP       = 4'd5;
  localparam logic [3:0] M_IDENT     = 4'd6;
  localparam logic [3:0] M_STR       = 4'd7;
  localparam logic [3:0] M_STR_ESC   = 4'd8;
  localparam logic [3:0] M_OP_HOLD   = 4'd9;
  localparam logic [3:0] M_LCMT      = 4'd10;
  localparam logic [3:0] M_BCMT      = 4'd11;
  localparam logic [3:0] M_BCMT_STAR = 4'd12;

  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  logic [3:0]                mode, mode_next;
  logic [7:0]                held_char, held_char_next;
  logic [POSITION_WIDTH-1:0] held_line, held_line_next;
  logic [POSITION_WIDTH-1:0] held_col, held_col_next;
  logic [7:0]                quote_char, quote_char_next;
  logic [POSITION_WIDTH-1:0] line_count, line_count_next;
  logic [POSITION_WIDTH-1:0] column_count, column_count_next;
  logic [POSITION_WIDTH-1:0] token_line, token_line_next;
  logic [POSITION_WIDTH-1:0] token_column, token_column_next;
  logic                      pend_valid, pend_valid_next;
  logic [7:0]                pend_char, pend_char_next;
  logic [3:0]                tok_kind, tok_kind_next;
  logic                      tok_emitted, tok_emitted_next;

  function automatic logic [15:0] clip(logic [POSITION_WIDTH-1:0] v);
    logic [POSITION_WIDTH+15:0] e;
    e = {16'd0, v};
    clip = (e > (POSITION_WIDTH+16)'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  always_comb begin
    logic [7:0]                c;
    logic [7:0]                sc;
    logic [POSITION_WIDTH-1:0] sl, scl;
    logic                      do_start;
    logic [1:0]                n;
    sqlscan_pkg::item_t [2:0]  items;

    c = char_code;
    n = 2'd0;
    items = '0;
    do_start = 1'b0;
    sc = c;
    sl = line_count;
    scl = column_count;
    mode_next = mode;
    held_char_next = held_char;
    held_line_next = held_line;
    held_col_next = held_col;
    quote_char_next = quote_char;
    line_count_next = line_count;
    column_count_next = column_count;
    token_line_next = token_line;
    token_column_next = token_column;
    pend_valid_next = pend_valid;
    pend_char_next = pend_char;
    tok_kind_next = tok_kind;
    tok_emitted_next = tok_emitted;

    if (end_of_input) begin
      // complete the open token, then close the text
      if (mode != M_IDLE && mode != M_OP_HOLD && mode != M_LCMT && mode != M_BCMT &&
          mode != M_BCMT_STAR && pend_valid) begin
        items[n] = sqlscan_pkg::mk_item(tok_kind, pend_char, 1'b1, !tok_emitted, 1'b1,
                                        clip(token_line), clip(token_column));
        n = n + 2'd1;
      end
      case (mode)
        M_INT_DOT: begin
          items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_DOT, held_char, 1'b1, 1'b1, 1'b1,
                                          clip(held_line), clip(held_col));
          n = n + 2'd1;
        end
        M_FRAC_E: begin
          items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_IDENT, held_char, 1'b1, 1'b1,
                                          1'b1, clip(held_line), clip(held_col));
          n = n + 2'd1;
        end
        M_OP_HOLD: begin
          items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_OP, held_char, 1'b1, 1'b1, 1'b1,
                                          clip(held_line), clip(held_col));
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (mode == M_STR || mode == M_STR_ESC) begin
        items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_ERROR, 8'd0, 1'b0, 1'b1, 1'b1,
                                        clip(token_line), clip(token_column));
      end else begin
        items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                        clip(line_count), clip(column_count));
      end
      n = n + 2'd1;
      mode_next = M_IDLE;
      held_char_next = 8'd0;
      held_line_next = '0;
      held_col_next = '0;
      quote_char_next = 8'd0;
      line_count_next = POS_ONE;
      column_count_next = POS_ONE;
      token_line_next = POS_ONE;
      token_column_next = POS_ONE;
      pend_valid_next = 1'b0;
      pend_char_next = 8'd0;
      tok_kind_next = sqlscan_pkg::K_INT;
      tok_emitted_next = 1'b0;
    end else begin
      unique case (mode)
        M_INT, M_FRAC, M_EXP, M_IDENT: begin
          if (sqlscan_pkg::is_digit(c) ||
              (mode == M_IDENT && sqlscan_pkg::is_alpha(c))) begin
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind_next, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b0,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_char_next = c;
          end else if (mode == M_INT && c == 8'h2e) begin
            held_char_next = c;
            held_line_next = line_count;
            held_col_next = column_count;
            mode_next = M_INT_DOT;
          end else if (mode == M_FRAC && (c == 8'h65 || c == 8'h45)) begin
            held_char_next = c;
            held_line_next = line_count;
            held_col_next = column_count;
            mode_next = M_FRAC_E;
          end else begin
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind_next, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b1,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
              pend_valid_next = 1'b0;
            end
            do_start = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (sqlscan_pkg::is_digit(c)) begin
            // fraction confirmed: the token becomes a float
            tok_kind_next = sqlscan_pkg::K_FLOAT;
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_FLOAT, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b0,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
            end
            items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_FLOAT, held_char, 1'b1,
                                            !tok_emitted_next, 1'b0,
                                            clip(token_line_next), clip(token_column_next));
            n = n + 2'd1;
            tok_emitted_next = 1'b1;
            pend_valid_next = 1'b1;
            pend_char_next = c;
            mode_next = M_FRAC;
          end else begin
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind_next, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b1,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
              pend_valid_next = 1'b0;
            end
            token_line_next = held_line;
            token_column_next = held_col;
            items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_DOT, held_char, 1'b1, 1'b1, 1'b1,
                                            clip(held_line), clip(held_col));
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_FRAC_E: begin
          if (sqlscan_pkg::is_digit(c) || c == 8'h2b || c == 8'h2d) begin
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind_next, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b0,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
            end
            items[n] = sqlscan_pkg::mk_item(tok_kind_next, held_char, 1'b1,
                                            !tok_emitted_next, 1'b0,
                                            clip(token_line_next), clip(token_column_next));
            n = n + 2'd1;
            tok_emitted_next = 1'b1;
            pend_valid_next = 1'b1;
            pend_char_next = c;
            mode_next = M_EXP;
          end else begin
            // close the number, then the held letter opens an identifier
            if (pend_valid_next) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind_next, pend_char_next, 1'b1,
                                              !tok_emitted_next, 1'b1,
                                              clip(token_line_next), clip(token_column_next));
              n = n + 2'd1;
            end
            tok_kind_next = sqlscan_pkg::K_IDENT;
            token_line_next = held_line;
            token_column_next = held_col;
            mode_next = M_IDENT;
            if (sqlscan_pkg::is_alpha(c)) begin
              items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_IDENT, held_char, 1'b1, 1'b1,
                                              1'b0, clip(held_line), clip(held_col));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
              pend_valid_next = 1'b1;
              pend_char_next = c;
            end else begin
              items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_IDENT, held_char, 1'b1, 1'b1,
                                              1'b1, clip(held_line), clip(held_col));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
              pend_valid_next = 1'b0;
              do_start = 1'b1;
            end
          end
        end
        M_STR: begin
          if (c == quote_char) begin
            if (pend_valid) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind, pend_char, 1'b1, !tok_emitted, 1'b1,
                                              clip(token_line), clip(token_column));
            end else begin
              items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_STRING, 8'd0, 1'b0, 1'b1, 1'b1,
                                              clip(token_line), clip(token_column));
            end
            n = n + 2'd1;
            tok_emitted_next = 1'b1;
            pend_valid_next = 1'b0;
            mode_next = M_IDLE;
          end else if (c == 8'h5c) begin
            mode_next = M_STR_ESC;
          end else begin
            if (pend_valid) begin
              items[n] = sqlscan_pkg::mk_item(tok_kind, pend_char, 1'b1, !tok_emitted, 1'b0,
                                              clip(token_line), clip(token_column));
              n = n + 2'd1;
              tok_emitted_next = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_char_next = c;
          end
        end
        M_STR_ESC: begin
          if (pend_valid) begin
            items[n] = sqlscan_pkg::mk_item(tok_kind, pend_char, 1'b1, !tok_emitted, 1'b0,
                                            clip(token_line), clip(token_column));
            n = n + 2'd1;
            tok_emitted_next = 1'b1;
          end
          pend_valid_next = 1'b1;
          case (c)
            8'h6e:   pend_char_next = 8'd10;
            8'h74:   pend_char_next = 8'd9;
            8'h72:   pend_char_next = 8'd13;
            default: pend_char_next = c;
          endcase
          mode_next = M_STR;
        end
        M_OP_HOLD: begin
          if ((c == 8'h3d && (held_char == 8'h3c || held_char == 8'h3e ||
                              held_char == 8'h21 || held_char == 8'h3d)) ||
              (held_char == 8'h3c && c == 8'h3e)) begin
            items[0] = sqlscan_pkg::mk_item(sqlscan_pkg::K_OP, held_char, 1'b1, 1'b1, 1'b0,
                                            clip(held_line), clip(held_col));
            items[1] = sqlscan_pkg::mk_item(sqlscan_pkg::K_OP, c, 1'b1, 1'b0, 1'b1,
                                            clip(held_line), clip(held_col));
            n = 2'd2;
            mode_next = M_IDLE;
          end else if (held_char == 8'h2d && c == 8'h2d) begin
            mode_next = M_LCMT;
          end else if (held_char == 8'h2f && c == 8'h2a) begin
            mode_next = M_BCMT;
          end else begin
            token_line_next = held_line;
            token_column_next = held_col;
            items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_OP, held_char, 1'b1, 1'b1, 1'b1,
                                            clip(held_line), clip(held_col));
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_LCMT: begin
          if (c == 8'h0a) mode_next = M_IDLE;
        end
        M_BCMT: begin
          if (c == 8'h2a) mode_next = M_BCMT_STAR;
        end
        M_BCMT_STAR: begin
          if (c == 8'h2f) mode_next = M_IDLE;
          else if (c != 8'h2a) mode_next = M_BCMT;
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_next = M_IDLE;
        if (sqlscan_pkg::is_space(sc)) begin
          mode_next = M_IDLE;
        end else if (sqlscan_pkg::is_digit(sc) || sqlscan_pkg::is_alpha(sc)) begin
          tok_kind_next = sqlscan_pkg::is_digit(sc) ? sqlscan_pkg::K_INT :
                                                      sqlscan_pkg::K_IDENT;
          mode_next = sqlscan_pkg::is_digit(sc) ? M_INT : M_IDENT;
          token_line_next = sl;
          token_column_next = scl;
          tok_emitted_next = 1'b0;
          pend_valid_next = 1'b1;
          pend_char_next = sc;
        end else if (sc == 8'h27 || sc == 8'h22) begin
          tok_kind_next = sqlscan_pkg::K_STRING;
          token_line_next = sl;
          token_column_next = scl;
          tok_emitted_next = 1'b0;
          pend_valid_next = 1'b0;
          quote_char_next = sc;
          mode_next = M_STR;
        end else begin
          token_line_next = sl;
          token_column_next = scl;
          case (sc) inside
            8'h2d, 8'h2f, 8'h3c, 8'h3e, 8'h21, 8'h3d: begin
              held_char_next = sc;
              held_line_next = sl;
              held_col_next = scl;
              mode_next = M_OP_HOLD;
            end
            8'h2c, 8'h3b, 8'h28, 8'h29, 8'h2e, 8'h2b, 8'h2a, 8'h25: begin
              case (sc)
                8'h2c:   items[n].kind = sqlscan_pkg::K_COMMA;
                8'h3b:   items[n].kind = sqlscan_pkg::K_SEMI;
                8'h28:   items[n].kind = sqlscan_pkg::K_LPAREN;
                8'h29:   items[n].kind = sqlscan_pkg::K_RPAREN;
                8'h2e:   items[n].kind = sqlscan_pkg::K_DOT;
                default: items[n].kind = sqlscan_pkg::K_OP;
              endcase
              items[n] = sqlscan_pkg::mk_item(items[n].kind, sc, 1'b1, 1'b1, 1'b1,
                                              clip(sl), clip(scl));
              n = n + 2'd1;
            end
            default: begin
              items[n] = sqlscan_pkg::mk_item(sqlscan_pkg::K_UNKNOWN, sc, 1'b1, 1'b1, 1'b1,
                                              clip(sl), clip(scl));
              n = n + 2'd1;
            end
          endcase
        end
      end

      // advance the position after the byte
      if (c == 8'h0a) begin
        if (line_count != POS_MAX) line_count_next = line_count + POS_ONE;
        column_count_next = POS_ONE;
      end else if (column_count != POS_MAX) begin
        column_count_next = column_count + POS_ONE;
      end
    end

    push.n = accept ? n : 2'd0;
    push.item = items;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      held_char <= 8'd0;
      held_line <= '0;
      held_col <= '0;
      quote_char <= 8'd0;
      line_count <= POS_ONE;
      column_count <= POS_ONE;
      token_line <= POS_ONE;
      token_column <= POS_ONE;
      pend_valid <= 1'b0;
      pend_char <= 8'd0;
      tok_kind <= sqlscan_pkg::K_INT;
      tok_emitted <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      held_char <= held_char_next;
      held_line <= held_line_next;
      held_col <= held_col_next;
      quote_char <= quote_char_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      token_line <= token_line_next;
      token_column <= token_column_next;
      pend_valid <= pend_valid_next;
      pend_char <= pend_char_next;
      tok_kind <= tok_kind_next;
      tok_emitted <= tok_emitted_next;
    end
  end

endmodule

// ===== rtl/core/sqlscan_queue.sv =====
module sqlscan_queue (
  input  logic                clk,
  input  logic                rst,
  input  sqlscan_pkg::push_t  push,
  output logic                space_ok,
  output sqlscan_pkg::qstat_t stat,
  output sqlscan_pkg::item_t  out_item,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int QAW = sqlscan_pkg::QAW;

  sqlscan_pkg::item_t mem [sqlscan_pkg::QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count, count_next;
  logic           do_pop;

  assign do_pop = (count != '0) && (!out_valid || out_ready);
  assign count_next = count + (QAW+1)'(push.n) - (QAW+1)'(do_pop);
  assign space_ok = count <= (QAW+1)'(sqlscan_pkg::QDEPTH - sqlscan_pkg::MAX_RES);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < sqlscan_pkg::MAX_RES; i++) begin
      if (2'(i) < push.n) mem[wptr + QAW'(i)] <= push.item[i];
    end
    if (do_pop) out_item <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      wptr <= wptr + QAW'(push.n);
      if (do_pop) rptr <= rptr + QAW'(1);
      count <= count_next;
      if (do_pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sql_token_scanner.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    char_code, end_of_input
// out       out_valid / out_ready  token_kind, value_char, has_char, token_first,
//                                  token_last, start_line, start_column
//
// One byte is taken per cycle while in_ready is high; it yields zero to three token
// items at once. Items pass through an 8-entry queue and leave at one per cycle while
// out_ready allows, so the input rate is set by the output drain when bytes yield more
// than one item each. in_ready is high while the queue has room for three items.
// Synchronous reset empties the queue and returns the scanner to line 1, column 1.
`include "assert_macros.svh"
module sql_token_scanner #(
  parameter int POSITION_WIDTH = sqlscan_pkg::POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [7:0]  value_char,
  output logic        has_char,
  output logic        token_first,
  output logic        token_last,
  output logic [15:0] start_line,
  output logic [15:0] start_column
);

  sqlscan_pkg::push_t  push;
  sqlscan_pkg::qstat_t stat;
  sqlscan_pkg::item_t  item;
  logic                space_ok;

  // Accept a byte only while the queue can absorb the worst case of a step.
  assign in_ready = space_ok;

  // Front: classify the byte and produce this step's token items.
  sqlscan_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_valid && in_ready),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .push         (push)
  );

  // Back: buffer items and drain them one per cycle through the output register while out_ready allows.
  sqlscan_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .stat      (stat),
    .out_item  (item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  assign token_kind   = item.kind;
  assign value_char   = item.ch;
  assign has_char     = item.has;
  assign token_first  = item.first;
  assign token_last   = item.last;
  assign start_line   = item.line;
  assign start_column = item.col;

  `SCN_ASSERT(a_q_bound, stat.count <= (sqlscan_pkg::QAW+1)'(sqlscan_pkg::QDEPTH), "queue overflow")
  `SCN_ASSERT(a_ready_room, in_ready |-> stat.count <= (sqlscan_pkg::QAW+1)'(sqlscan_pkg::QDEPTH - sqlscan_pkg::MAX_RES), "ready without room")
  `SCN_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "output valid after reset")
  `SCN_ASSERT(a_end_shape, (out_valid && (token_kind == sqlscan_pkg::K_END || token_kind == sqlscan_pkg::K_ERROR)) |-> (!has_char && token_first && token_last), "malformed end item")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // Scanner modes of the predictor; they track how far the current token has got.
  typedef enum int {
    S_IDLE, S_INT, S_INT_DOT, S_FRAC, S_FRAC_E, S_EXP, S_IDENT, S_STR, S_STR_ESC,
    S_OP_HOLD, S_LCMT, S_BCMT, S_BCMT_STAR
  } scan_mode_t;

  typedef struct {
    logic [7:0] c;
    logic       eoi;
  } text_byte_t;

  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  token_kind;
  logic [7:0]  value_char;
  logic        has_char;
  logic        token_first;
  logic        token_last;
  logic [15:0] start_line;
  logic [15:0] start_column;

  sql_token_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .value_char(value_char), .has_char(has_char),
    .token_first(token_first), .token_last(token_last),
    .start_line(start_line), .start_column(start_column)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending text bytes, and the token items the scanner still owes us.
  text_byte_t         text_q[$];
  sqlscan_pkg::item_t token_q[$];

  int sent_cnt = 0;
  int taken_cnt = 0;
  int item_cnt = 0;
  int text_cnt = 0;
  int error_cnt = 0;
  int total_bytes = 0;
  int cycle_cnt = 0;
  bit long_hold = 1'b0;

  // Predictor state: a software copy of the scanner.
  scan_mode_t mode;
  logic [7:0] held_ch, quote_ch, pend_ch;
  logic [3:0] tok_kind;
  logic       pend_v, tok_sent;
  int         line_cnt, col_cnt, tok_ln, tok_cl, held_ln, held_cl;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [15:0] clip_pos(int v);
    return v > 65535 ? 16'hFFFF : v[15:0];
  endfunction

  task automatic clear_scanner();
    mode = S_IDLE;
    held_ch = 8'd0; quote_ch = 8'd0; pend_ch = 8'd0;
    tok_kind = sqlscan_pkg::K_INT; pend_v = 1'b0; tok_sent = 1'b0;
    line_cnt = 1; col_cnt = 1; tok_ln = 1; tok_cl = 1; held_ln = 0; held_cl = 0;
  endtask

  task automatic expect_item(logic [3:0] k, logic [7:0] c, logic h, logic f, logic l,
                             int ln, int cl);
    sqlscan_pkg::item_t it;
    it.kind = k; it.ch = h ? c : 8'd0; it.has = h; it.first = f; it.last = l;
    it.line = clip_pos(ln); it.col = clip_pos(cl);
    token_q = {token_q, it};
  endtask

  task automatic flush_char(logic last);
    if (pend_v) begin
      expect_item(tok_kind, pend_ch, 1'b1, !tok_sent, last, tok_ln, tok_cl);
      tok_sent = 1'b1;
      pend_v = 1'b0;
    end
  endtask

  task automatic push_char(logic [7:0] c);
    flush_char(1'b0);
    pend_v = 1'b1;
    pend_ch = c;
  endtask

  task automatic open_token(logic [3:0] k, int ln, int cl);
    tok_kind = k; tok_ln = ln; tok_cl = cl; tok_sent = 1'b0; pend_v = 1'b0;
  endtask

  task automatic single_token(logic [3:0] k, logic [7:0] c, int ln, int cl);
    tok_ln = ln; tok_cl = cl;
    expect_item(k, c, 1'b1, 1'b1, 1'b1, ln, cl);
  endtask

  task automatic hold_byte(logic [7:0] c, int ln, int cl, scan_mode_t m);
    held_ch = c; held_ln = ln; held_cl = cl; mode = m;
  endtask

  // Begin whatever token byte c opens, from the idle mode.
  task automatic start_token(logic [7:0] c, int ln, int cl);
    mode = S_IDLE;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      // whitespace: drop
    end else if (digit_c(c)) begin
      open_token(sqlscan_pkg::K_INT, ln, cl); push_char(c); mode = S_INT;
    end else if (c == "'" || c == "\"") begin
      open_token(sqlscan_pkg::K_STRING, ln, cl); quote_ch = c; mode = S_STR;
    end else if (alpha_c(c)) begin
      open_token(sqlscan_pkg::K_IDENT, ln, cl); push_char(c); mode = S_IDENT;
    end else begin
      case (c)
        ",": single_token(sqlscan_pkg::K_COMMA, c, ln, cl);
        ";": single_token(sqlscan_pkg::K_SEMI, c, ln, cl);
        "(": single_token(sqlscan_pkg::K_LPAREN, c, ln, cl);
        ")": single_token(sqlscan_pkg::K_RPAREN, c, ln, cl);
        ".": single_token(sqlscan_pkg::K_DOT, c, ln, cl);
        "+", "*", "%": single_token(sqlscan_pkg::K_OP, c, ln, cl);
        "-", "/", "<", ">", "!", "=": begin
          tok_ln = ln; tok_cl = cl;
          hold_byte(c, ln, cl, S_OP_HOLD);
        end
        default: single_token(sqlscan_pkg::K_UNKNOWN, c, ln, cl);
      endcase
    end
  endtask

  task automatic close_number(logic [7:0] c, int ln, int cl);
    flush_char(1'b1);
    start_token(c, ln, cl);
  endtask

  task automatic scan_byte(logic [7:0] c, int ln, int cl);
    logic [7:0] h;
    h = held_ch;
    case (mode)
      S_INT:
        if (digit_c(c)) push_char(c);
        else if (c == ".") hold_byte(c, ln, cl, S_INT_DOT);
        else close_number(c, ln, cl);
      S_INT_DOT:
        if (digit_c(c)) begin
          tok_kind = sqlscan_pkg::K_FLOAT; push_char(h); push_char(c); mode = S_FRAC;
        end else begin
          // number then a dot with no digit: int, then a dot token
          flush_char(1'b1);
          single_token(sqlscan_pkg::K_DOT, h, held_ln, held_cl);
          start_token(c, ln, cl);
        end
      S_FRAC:
        if (digit_c(c)) push_char(c);
        else if (c == "e" || c == "E") hold_byte(c, ln, cl, S_FRAC_E);
        else close_number(c, ln, cl);
      S_FRAC_E:
        if (digit_c(c) || c == "+" || c == "-") begin
          push_char(h); push_char(c); mode = S_EXP;
        end else begin
          // the 'e' was not an exponent: it opens an identifier
          flush_char(1'b1);
          start_token(h, held_ln, held_cl);
          scan_byte(c, ln, cl);
        end
      S_EXP:
        if (digit_c(c)) push_char(c);
        else close_number(c, ln, cl);
      S_IDENT:
        if (alpha_c(c) || digit_c(c)) push_char(c);
        else close_number(c, ln, cl);
      S_STR:
        if (c == quote_ch) begin
          if (pend_v) flush_char(1'b1);
          else expect_item(sqlscan_pkg::K_STRING, 8'd0, 1'b0, 1'b1, 1'b1, tok_ln, tok_cl);
          mode = S_IDLE;
        end else if (c == "\\") begin
          mode = S_STR_ESC;
        end else begin
          push_char(c);
        end
      S_STR_ESC: begin
        push_char(c == "n" ? 8'd10 : c == "t" ? 8'd9 : c == "r" ? 8'd13 : c);
        mode = S_STR;
      end
      S_OP_HOLD:
        if ((c == "=" && (h == "<" || h == ">" || h == "!" || h == "=")) ||
            (h == "<" && c == ">")) begin
          expect_item(sqlscan_pkg::K_OP, h, 1'b1, 1'b1, 1'b0, held_ln, held_cl);
          expect_item(sqlscan_pkg::K_OP, c, 1'b1, 1'b0, 1'b1, held_ln, held_cl);
          mode = S_IDLE;
        end else if (h == "-" && c == "-") begin
          mode = S_LCMT;
        end else if (h == "/" && c == "*") begin
          mode = S_BCMT;
        end else begin
          single_token(sqlscan_pkg::K_OP, h, held_ln, held_cl);
          start_token(c, ln, cl);
        end
      S_LCMT:
        if (c == 8'd10) mode = S_IDLE;
      S_BCMT:
        if (c == "*") mode = S_BCMT_STAR;
      S_BCMT_STAR:
        if (c == "/") mode = S_IDLE;
        else if (c != "*") mode = S_BCMT;
      default:
        start_token(c, ln, cl);
    endcase
  endtask

  // End of text: complete the open token, then the end or error item.
  task automatic close_text();
    bit unterminated;
    unterminated = 1'b0;
    case (mode)
      S_INT, S_FRAC, S_EXP, S_IDENT: flush_char(1'b1);
      S_INT_DOT: begin
        flush_char(1'b1);
        single_token(sqlscan_pkg::K_DOT, held_ch, held_ln, held_cl);
      end
      S_FRAC_E: begin
        flush_char(1'b1);
        single_token(sqlscan_pkg::K_IDENT, held_ch, held_ln, held_cl);
      end
      S_STR, S_STR_ESC: begin
        flush_char(1'b1);
        expect_item(sqlscan_pkg::K_ERROR, 8'd0, 1'b0, 1'b1, 1'b1, tok_ln, tok_cl);
        unterminated = 1'b1;
      end
      S_OP_HOLD: single_token(sqlscan_pkg::K_OP, held_ch, held_ln, held_cl);
      default: ;
    endcase
    if (!unterminated) begin
      expect_item(sqlscan_pkg::K_END, 8'd0, 1'b0, 1'b1, 1'b1, line_cnt, col_cnt);
    end
    clear_scanner();
  endtask

  task automatic predict_request(logic [7:0] c, logic eoi);
    if (eoi) begin
      close_text();
    end else begin
      scan_byte(c, line_cnt, col_cnt);
      if (c == 8'd10) begin
        if (line_cnt < 65535) line_cnt++;
        col_cnt = 1;
      end else if (col_cnt < 65535) begin
        col_cnt++;
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on item %0d: %s got %0d expected %0d", item_cnt, what, got, want);
    error_cnt++;
  endtask

  // Stimulus building.
  task automatic add_byte(logic [7:0] c);
    text_byte_t b;
    b.c = c; b.eoi = 1'b0;
    text_q = {text_q, b};
  endtask

  task automatic add_end();
    text_byte_t b;
    b.c = 8'($urandom_range(0, 255)); b.eoi = 1'b1;
    text_q = {text_q, b};
  endtask

  task automatic add_string(string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) add_byte(8'($urandom_range(48, 57)));
  endtask

  // Append one random fragment of text; most are well formed tokens.
  task automatic add_fragment();
    logic [7:0] q, c;
    int         n;
    case ($urandom_range(0, 11))
      0: add_digits($urandom_range(1, 4));
      1: begin
        add_digits($urandom_range(1, 3));
        add_byte(".");
        if ($urandom_range(0, 3) != 0) add_digits($urandom_range(1, 3));
        if ($urandom_range(0, 1)) begin
          add_byte($urandom_range(0, 1) ? "e" : "E");
          case ($urandom_range(0, 3))
            0: add_byte("+");
            1: add_byte("-");
            2: add_byte("z");
            default: ;
          endcase
          if ($urandom_range(0, 3) != 0) add_digits($urandom_range(1, 2));
        end
      end
      2: begin
        n = $urandom_range(1, 5);
        add_byte(8'($urandom_range(0, 1) ? $urandom_range(97, 122) : $urandom_range(65, 90)));
        repeat (n - 1) begin
          case ($urandom_range(0, 3))
            0: add_byte("_");
            1: add_digits(1);
            default: add_byte(8'($urandom_range(97, 122)));
          endcase
        end
      end
      3: begin
        q = $urandom_range(0, 1) ? "'" : "\"";
        add_byte(q);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte("\\");
            case ($urandom_range(0, 4))
              0: add_byte("n");
              1: add_byte("t");
              2: add_byte("r");
              3: add_byte(q);
              default: add_byte(8'($urandom_range(0, 255)));
            endcase
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == q || c == "\\") c = "a";
            add_byte(c);
          end
        end
        if ($urandom_range(0, 9) != 0) add_byte(q);
      end
      4: begin
        case ($urandom_range(0, 4))
          0: add_string("<=");
          1: add_string(">=");
          2: add_string("<>");
          3: add_string("!=");
          default: add_string("==");
        endcase
      end
      5: begin
        case ($urandom_range(0, 12))
          0: add_byte("+"); 1: add_byte("-"); 2: add_byte("*"); 3: add_byte("/");
          4: add_byte("%"); 5: add_byte("<"); 6: add_byte(">"); 7: add_byte("!");
          8: add_byte("="); 9: add_byte(","); 10: add_byte(";"); 11: add_byte("(");
          default: add_byte(")");
        endcase
      end
      6: add_byte(8'($urandom_range(0, 1) ? 10 : $urandom_range(0, 1) ? 32 : $urandom_range(9, 13)));
      7: begin
        add_string("--");
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) != 0) add_byte(8'd10);
      end
      8: begin
        add_string("/*");
        repeat ($urandom_range(0, 3)) add_byte($urandom_range(0, 1) ? "*" : "x");
        if ($urandom_range(0, 5) != 0) add_string("*/");
      end
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) add_byte(" ");
  endtask

  // Sender: offer the next request once the current one has been taken.
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst && taken_cnt == sent_cnt) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (text_q.size() > 0 && taken_cnt < total_bytes * 4 / 5 &&
                   $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        char_code <= text_q[0].c;
        end_of_input <= text_q[0].eoi;
        void'(text_q.pop_front());
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off below.
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (taken_cnt < total_bytes * 4 / 5 && $urandom_range(0, 6) == 0) begin
      out_gap <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold the output off for a long stretch so the queue fills and in_ready drops.
  initial begin
    wait (taken_cnt > 60);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    long_hold = 1'b0;
  end

  // Predict on each accepted request; check each accepted token item.
  always @(posedge clk) begin
    sqlscan_pkg::item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_request(char_code, end_of_input);
        if (end_of_input) text_cnt++;
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          report_mismatch("unexpected item, token_kind", token_kind, -1);
        end else begin
          want = token_q.pop_front();
          if (token_kind != want.kind) report_mismatch("token_kind", token_kind, want.kind);
          if (value_char != want.ch) report_mismatch("value_char", value_char, want.ch);
          if (has_char != want.has) report_mismatch("has_char", has_char, want.has);
          if (token_first != want.first) report_mismatch("token_first", token_first, want.first);
          if (token_last != want.last) report_mismatch("token_last", token_last, want.last);
          if (start_line != want.line) report_mismatch("start_line", start_line, want.line);
          if (start_column != want.col) report_mismatch("start_column", start_column, want.col);
        end
        item_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_scanner();
    // Directed: float with exponent, escapes, empty string, operator pair,
    // dot without digit, a lone minus, open block comment, open string.
    add_string("7.5e+2 'a\\t\\'' \"\" <> 3.x -1");
    add_end();
    add_string("/*");
    add_end();
    add_string("'q");
    add_end();
    while (text_q.size() < 270) begin
      repeat ($urandom_range(1, 12)) add_fragment();
      add_end();
    end
    total_bytes = text_q.size();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (text_q.size() == 0 && taken_cnt == sent_cnt && !in_valid);
    wait (token_q.size() == 0);
    repeat (30) @(posedge clk);
    $display("%0d requests in %0d texts, %0d token items checked", taken_cnt, text_cnt,
             item_cnt);
    if (error_cnt == 0 && token_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d items missing", error_cnt, token_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sqlscan_pkg.sv
rtl/core/sqlscan_front.sv
rtl/core/sqlscan_queue.sv
rtl/core/sql_token_scanner.sv
tb/sv/testbench.sv
